FILE: hw/rtl/stt_pkg.sv
package stt_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    CMD_PROBE = 2'd0,
    CMD_STORE = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    BND_EXACT = 2'd0,
    BND_UPPER = 2'd1,
    BND_LOWER = 2'd2,
    BND_NONE  = 2'd3
  } bound_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_CLEAR
  } state_t;

  // One slot of the data memory
  typedef struct packed {
    logic [63:0]        key;
    logic [31:0]        move;
    logic signed [7:0]  depth;
    logic signed [15:0] score;
    bound_t             bound;
  } entry_t;

endpackage

FILE: hw/rtl/search_transposition_table.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+------------------------------------------------
// input    | in_valid/in_stall  | command position_key search_depth window_low
//          |                    | window_high move_word score bound_type
// output   | out_valid/out_stall| occupied usable probe_score slot_move was_stored
//
// Probe, store and unused command: accept, then one read of the slot memories;
// a store writes back when its result is loaded into the output register.
// Clear: a sweep zeroes the valid memory one entry per cycle, and the reply
// is loaded once the sweep ends and the output register is free.
// After reset the same sweep runs with in_stall high and gives no reply.
// A result waits in the output register under out_stall; the next transaction
// is accepted meanwhile but its result is held until the register frees.
module search_transposition_table (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          command,
  input  logic [63:0]         position_key,
  input  logic signed [7:0]   search_depth,
  input  logic signed [15:0]  window_low,
  input  logic signed [15:0]  window_high,
  input  logic [31:0]         move_word,
  input  logic signed [15:0]  score,
  input  logic [1:0]          bound_type,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                occupied,
  output logic                usable,
  output logic signed [15:0]  probe_score,
  output logic [31:0]         slot_move,
  output logic                was_stored
);
  import stt_pkg::*;

  state_t state, state_next;
  logic [IDX_W-1:0] sweep_idx;
  logic clear_reply;

  // Captured transaction
  cmd_t               it_cmd;
  logic [63:0]        it_key;
  logic signed [7:0]  it_depth;
  logic signed [15:0] it_alpha;
  logic signed [15:0] it_beta;
  logic [31:0]        it_move;
  logic signed [15:0] it_score;
  bound_t             it_bound;

  // Slot memories
  logic   valid_mem [TABLE_ENTRIES];
  entry_t data_mem  [TABLE_ENTRIES];
  logic   rd_valid;
  entry_t rd_entry;

  logic             accept, out_free, out_load;
  logic             vmem_we, vmem_wdata, dmem_we;
  logic [IDX_W-1:0] vmem_addr;
  entry_t           wr_entry;

  logic               res_occ, res_usable, res_stored;
  logic signed [15:0] res_score;
  logic [31:0]        res_move;
  logic               hit, skip;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      sweep_idx   <= '0;
      clear_reply <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        sweep_idx   <= '0;
        clear_reply <= 1'b1;
      end else if (state == ST_CLEAR && sweep_idx != LAST_IDX) begin
        sweep_idx <= sweep_idx + 1'b1;
      end
    end
  end

  // Transaction register
  always_ff @(posedge clk) begin
    if (accept) begin
      it_cmd   <= cmd_t'(command);
      it_key   <= position_key;
      it_depth <= search_depth;
      it_alpha <= window_low;
      it_beta  <= window_high;
      it_move  <= move_word;
      it_score <= score;
      it_bound <= bound_t'(bound_type);
    end
  end

  // Valid memory
  always_ff @(posedge clk) begin
    if (vmem_we) valid_mem[vmem_addr] <= vmem_wdata;
    if (accept)  rd_valid <= valid_mem[position_key[IDX_W-1:0]];
  end

  // Data memory
  always_ff @(posedge clk) begin
    if (dmem_we) data_mem[it_key[IDX_W-1:0]] <= wr_entry;
    if (accept)  rd_entry <= data_mem[position_key[IDX_W-1:0]];
  end

  assign wr_entry = '{key: it_key, move: it_move, depth: it_depth,
                      score: it_score, bound: it_bound};

  // Slot evaluation
  assign hit  = rd_valid && (rd_entry.key == it_key) && (rd_entry.depth >= it_depth);
  assign skip = rd_valid && (it_depth < rd_entry.depth);

  always_comb begin
    res_occ    = 1'b0;
    res_usable = 1'b0;
    res_score  = '0;
    res_move   = '0;
    res_stored = 1'b0;
    if (state == ST_LOOK) begin
      case (it_cmd)
        CMD_PROBE: begin
          res_occ  = rd_valid;
          res_move = rd_valid ? rd_entry.move : 32'd0;
          case (rd_entry.bound)
            BND_EXACT: begin
              res_usable = hit;
              res_score  = hit ? rd_entry.score : 16'sd0;
            end
            BND_UPPER: begin
              res_usable = hit && (rd_entry.score <= it_alpha);
              res_score  = res_usable ? it_alpha : 16'sd0;
            end
            BND_LOWER: begin
              res_usable = hit && (rd_entry.score >= it_beta);
              res_score  = res_usable ? it_beta : 16'sd0;
            end
            default: ;
          endcase
        end
        CMD_STORE: begin
          res_occ    = rd_valid;
          res_move   = rd_valid ? rd_entry.move : 32'd0;
          res_stored = !skip;
        end
        default: ;
      endcase
    end
  end

  // Next state and memory control
  always_comb begin
    state_next = state;
    in_stall   = (state != ST_IDLE);
    out_load   = 1'b0;
    vmem_we    = 1'b0;
    vmem_wdata = 1'b0;
    vmem_addr  = it_key[IDX_W-1:0];
    dmem_we    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (cmd_t'(command) == CMD_CLEAR) ? ST_CLEAR : ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
          if (it_cmd == CMD_STORE && !skip) begin
            vmem_we    = 1'b1;
            vmem_wdata = 1'b1;
            dmem_we    = 1'b1;
          end
        end
      end
      ST_CLEAR: begin
        vmem_we   = 1'b1;
        vmem_addr = sweep_idx;
        if (sweep_idx == LAST_IDX && (!clear_reply || out_free)) begin
          out_load   = clear_reply;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      occupied    <= res_occ;
      usable      <= res_usable;
      probe_score <= res_score;
      slot_move   <= res_move;
      was_stored  <= res_stored;
    end
  end

endmodule

FILE: hw/rtl/stt_checker.sv
module stt_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               occupied,
  input logic               usable,
  input logic signed [15:0] probe_score,
  input logic               was_stored
);

  // A waiting result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // One transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted back to back");

  // A usable hit needs an occupied slot
  a_usable_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && usable |-> occupied)
    else $error("usable without occupied slot");

  // Score is zero unless usable
  a_score_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !usable |-> probe_score == 16'sd0)
    else $error("nonzero score on unusable result");

  // Store results never report usability
  a_store_not_usable: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_stored |-> !usable)
    else $error("store result flagged usable");

endmodule

bind search_transposition_table stt_checker u_stt_checker (.*);

FILE: tb/testbench.sv
module testbench;
  import stt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 600;

  // One input transaction
  typedef struct {
    cmd_t               cmd;
    logic [63:0]        key;
    logic signed [7:0]  depth;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [31:0]        mv;
    logic signed [15:0] sc;
    bound_t             bnd;
  } txn_t;

  // One output transaction
  typedef struct packed {
    logic               occupied;
    logic               usable;
    logic signed [15:0] score;
    logic [31:0]        move;
    logic               stored;
  } reply_t;

  // Shadow copy of the table plus the queue of replies still owed
  class reply_book;
    bit                 slot_full  [TABLE_ENTRIES];
    logic [63:0]        slot_key   [TABLE_ENTRIES];
    logic [31:0]        slot_mv    [TABLE_ENTRIES];
    logic signed [7:0]  slot_depth [TABLE_ENTRIES];
    logic signed [15:0] slot_sc    [TABLE_ENTRIES];
    bound_t             slot_bnd   [TABLE_ENTRIES];
    reply_t             owed[$];
    int                 errors;

    function new();
      foreach (slot_full[i]) slot_full[i] = 1'b0;
      errors = 0;
    endfunction

    // Update the shadow table and queue the reply this transaction earns
    function void apply(txn_t t);
      logic [IDX_W-1:0] idx;
      reply_t r;
      bit occ;
      idx = t.key[IDX_W-1:0];
      occ = slot_full[idx];
      r = '0;
      case (t.cmd)
        CMD_PROBE: begin
          r.occupied = occ;
          r.move = occ ? slot_mv[idx] : 32'd0;
          if (occ && slot_key[idx] == t.key && slot_depth[idx] >= t.depth) begin
            case (slot_bnd[idx])
              BND_EXACT: begin
                r.usable = 1'b1;
                r.score = slot_sc[idx];
              end
              BND_UPPER: if (slot_sc[idx] <= t.alpha) begin
                r.usable = 1'b1;
                r.score = t.alpha;
              end
              BND_LOWER: if (slot_sc[idx] >= t.beta) begin
                r.usable = 1'b1;
                r.score = t.beta;
              end
              default: ;
            endcase
          end
        end
        CMD_STORE: begin
          r.occupied = occ;
          r.move = occ ? slot_mv[idx] : 32'd0;
          // deeper entry already in the slot wins, whatever its key
          if (!(occ && t.depth < slot_depth[idx])) begin
            slot_full[idx] = 1'b1;
            slot_key[idx] = t.key;
            slot_mv[idx] = t.mv;
            slot_depth[idx] = t.depth;
            slot_sc[idx] = t.sc;
            slot_bnd[idx] = t.bnd;
            r.stored = 1'b1;
          end
        end
        CMD_CLEAR: foreach (slot_full[i]) slot_full[i] = 1'b0;
        default: ;
      endcase
      owed.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t exp;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected reply: occ=%0b usable=%0b score=%0d move=%h stored=%0b",
                   got.occupied, got.usable, got.score, got.move, got.stored);
        return;
      end
      exp = owed.pop_front();
      if (got.occupied !== exp.occupied || got.usable !== exp.usable ||
          got.score !== exp.score || got.move !== exp.move ||
          got.stored !== exp.stored) begin
        errors++;
        if (errors <= 10) begin
          $display("reply mismatch at %0t", $realtime);
          $display("  expected occ=%0b usable=%0b score=%0d move=%h stored=%0b",
                   exp.occupied, exp.usable, exp.score, exp.move, exp.stored);
          $display("  actual   occ=%0b usable=%0b score=%0d move=%h stored=%0b",
                   got.occupied, got.usable, got.score, got.move, got.stored);
        end
      end
    endfunction

    function int outstanding();
      return owed.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         command;
  logic [63:0]        position_key;
  logic signed [7:0]  search_depth;
  logic signed [15:0] window_low;
  logic signed [15:0] window_high;
  logic [31:0]        move_word;
  logic signed [15:0] score;
  logic [1:0]         bound_type;
  logic               out_valid;
  logic               out_stall;
  logic               occupied;
  logic               usable;
  logic signed [15:0] probe_score;
  logic [31:0]        slot_move;
  logic               was_stored;

  reply_book   book;
  bit          calm;
  int          cycles = 0;
  logic [63:0] key_pool[24];

  search_transposition_table uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .position_key(position_key), .search_depth(search_depth),
    .window_low(window_low), .window_high(window_high), .move_word(move_word),
    .score(score), .bound_type(bound_type),
    .out_valid(out_valid), .out_stall(out_stall),
    .occupied(occupied), .usable(usable), .probe_score(probe_score),
    .slot_move(slot_move), .was_stored(was_stored)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver backpressure
  always @(posedge clk) begin
    if (rst)
      out_stall <= 1'b0;
    else
      out_stall <= !calm && ($urandom_range(0, 99) < 8);
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      book.check_reply('{occupied, usable, probe_score, slot_move, was_stored});
  end

  function automatic txn_t mk(cmd_t c, logic [63:0] k, logic signed [7:0] d,
                              logic signed [15:0] a, logic signed [15:0] b,
                              logic [31:0] m, logic signed [15:0] s, bound_t bd);
    txn_t t;
    t.cmd = c; t.key = k; t.depth = d; t.alpha = a; t.beta = b;
    t.mv = m; t.sc = s; t.bnd = bd;
    return t;
  endfunction

  // Mostly keys that collide with each other, some fresh ones
  function automatic logic [63:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return key_pool[$urandom_range(0, 23)];
    else if (r < 85)
      return {$urandom(), 20'($urandom_range(0, 2**20 - 1)),
              key_pool[$urandom_range(0, 23)][IDX_W-1:0]};
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic signed [15:0] pick_value();
    if ($urandom_range(0, 99) < 70)
      return 16'(int'($urandom_range(0, 240)) - 120);
    return 16'($urandom());
  endfunction

  function automatic txn_t random_txn(cmd_t c);
    txn_t t;
    t.cmd = c;
    t.key = pick_key();
    if ($urandom_range(0, 99) < 70)
      t.depth = 8'(int'($urandom_range(0, 16)) - 4);
    else
      t.depth = 8'($urandom());
    t.alpha = pick_value();
    t.beta = pick_value();
    t.mv = $urandom();
    t.sc = pick_value();
    t.bnd = bound_t'($urandom_range(0, 3));
    return t;
  endfunction

  // Present one transaction and hold it until accepted
  task automatic send(txn_t t);
    while (!calm && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= t.cmd;
    position_key <= t.key;
    search_depth <= t.depth;
    window_low <= t.alpha;
    window_high <= t.beta;
    move_word <= t.mv;
    score <= t.sc;
    bound_type <= t.bnd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.apply(t);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    logic [63:0] k_ones, k_zero, k_alias;
    txn_t t;
    int r;
    book = new();
    calm = 1'b0;
    for (int i = 0; i < 8; i++) begin
      logic [IDX_W-1:0] idx;
      idx = IDX_W'($urandom());
      for (int j = 0; j < 3; j++)
        key_pool[i * 3 + j] = {$urandom(), 20'($urandom_range(0, 2**20 - 1)), idx};
    end
    rst <= 1'b1;
    in_valid <= 1'b0;
    command <= CMD_PROBE;
    position_key <= '0;
    search_depth <= '0;
    window_low <= '0;
    window_high <= '0;
    move_word <= '0;
    score <= '0;
    bound_type <= BND_EXACT;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    k_ones = '1;
    k_zero = '0;
    k_alias = {52'h5A5A5_A5A5A_5A5, {IDX_W{1'b1}}};

    // Directed: bounds, depth rules, aliasing, unused command, clear
    send(mk(CMD_PROBE, k_zero, 0, 0, 0, 0, 0, BND_EXACT));
    send(mk(CMD_STORE, k_ones, 5, 0, 0, '1, 16'sh7FFF, BND_EXACT));
    send(mk(CMD_PROBE, k_ones, 5, 0, 0, 0, 0, BND_EXACT));
    send(mk(CMD_PROBE, k_ones, 6, 0, 0, 0, 0, BND_EXACT));
    send(mk(CMD_STORE, k_alias, 4, 0, 0, 32'h1234_5678, 7, BND_EXACT));
    send(mk(CMD_STORE, k_alias, 5, 0, 0, 32'h8765_4321, -100, BND_UPPER));
    send(mk(CMD_PROBE, k_alias, 5, -100, 0, 0, 0, BND_EXACT));
    send(mk(CMD_PROBE, k_alias, 5, -101, 0, 0, 0, BND_EXACT));
    send(mk(CMD_PROBE, k_ones, 0, 0, 0, 0, 0, BND_EXACT));
    send(mk(CMD_STORE, k_zero, -128, 0, 0, 0, 16'sh8000, BND_LOWER));
    send(mk(CMD_PROBE, k_zero, -128, 0, 16'sh8000, 0, 0, BND_EXACT));
    send(mk(CMD_PROBE, k_zero, -128, 0, -32767, 0, 0, BND_EXACT));
    send(mk(CMD_STORE, k_zero, 127, 0, 0, 32'hDEAD_BEEF, 0, BND_NONE));
    send(mk(CMD_PROBE, k_zero, -128, 16'sh7FFF, 16'sh8000, 0, 0, BND_EXACT));
    send(mk(CMD_STORE, k_zero, -128, 0, 0, 32'h0BAD_F00D, 1, BND_EXACT));
    send(mk(CMD_NONE, k_ones, -1, -1, -1, '1, -1, BND_NONE));
    send(mk(CMD_PROBE, k_zero, 127, 16'sh7FFF, 16'sh7FFF, 0, 0, BND_EXACT));
    send(mk(CMD_CLEAR, k_ones, -1, -1, -1, '1, -1, BND_NONE));
    send(mk(CMD_PROBE, k_ones, 0, 0, 0, 0, 0, BND_EXACT));
    send(mk(CMD_STORE, k_ones, 127, 0, 0, 32'h0000_0001, 16'sh8000, BND_EXACT));
    send(mk(CMD_PROBE, k_ones, 127, 16'sh8000, 16'sh7FFF, 0, 0, BND_EXACT));
    drain();

    // Random: store-then-probe pairs dominate, with noise and rare clears
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 150 && n < 300);
      if (n == 300)
        drain();
      r = $urandom_range(0, 99);
      if (r < 2) begin
        send(random_txn(CMD_CLEAR));
      end else if (r < 6) begin
        send(random_txn(CMD_NONE));
      end else if (r < 40) begin
        t = random_txn(CMD_STORE);
        send(t);
        t.cmd = CMD_PROBE;
        t.depth = t.depth - 8'($urandom_range(0, 2));
        t.alpha = t.sc + 16'(int'($urandom_range(0, 4)) - 2);
        t.beta = t.sc + 16'(int'($urandom_range(0, 4)) - 2);
        send(t);
        n++;
      end else if (r < 70) begin
        send(random_txn(CMD_PROBE));
      end else begin
        send(random_txn(CMD_STORE));
      end
    end
    calm = 1'b0;

    drain();
    repeat (20) @(posedge clk);
    if (book.errors == 0 && book.outstanding() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
